// File: sv/chc_pkg.sv
// ----------------------------------------------------------------------------
// chc_pkg: shared constants and tables for the compass heading block
// Holds the sample and fixed-point widths, the CORDIC step count and the
// arctangent table in degrees with sixteen fractional bits.
// ----------------------------------------------------------------------------
package chc_pkg;

	localparam int SAMPLE_BITS  = 12;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int CORR_W       = SAMPLE_BITS + 1;
	localparam int VEC_W        = CORR_W + FRAC_BITS + 3;
	localparam int Z_W          = 26;
	localparam int DEG_W        = 9;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

	localparam logic signed [Z_W-1:0] HALF_TURN_Q = Z_W'(180 << FRAC_BITS);
	localparam logic signed [Z_W-1:0] FULL_TURN_Q = Z_W'(360 << FRAC_BITS);
	localparam logic signed [Z_W-1:0] ROUND_HALF  = Z_W'(1 << (FRAC_BITS - 1));
	localparam logic [DEG_W-1:0]      DEG_FULL    = DEG_W'(360);

	// Entry i is round(atan(2^-i) * 180/pi * 2^16); entries past the table are zero.
	function automatic logic signed [Z_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] a;
		case (idx)
			0:  a = Z_W'(2949120);
			1:  a = Z_W'(1740967);
			2:  a = Z_W'(919879);
			3:  a = Z_W'(466945);
			4:  a = Z_W'(234379);
			5:  a = Z_W'(117304);
			6:  a = Z_W'(58666);
			7:  a = Z_W'(29335);
			8:  a = Z_W'(14668);
			9:  a = Z_W'(7334);
			10: a = Z_W'(3667);
			11: a = Z_W'(1833);
			12: a = Z_W'(917);
			13: a = Z_W'(458);
			14: a = Z_W'(229);
			15: a = Z_W'(115);
			16: a = Z_W'(57);
			17: a = Z_W'(29);
			18: a = Z_W'(14);
			19: a = Z_W'(7);
			20: a = Z_W'(4);
			21: a = Z_W'(2);
			22: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: sv/compass_heading_with_calibration.sv
// ----------------------------------------------------------------------------
// compass_heading_with_calibration: hard-iron corrected compass heading
// Tracks per-axis extremes from calibration requests and turns heading
// requests into whole degrees with an iterative CORDIC.
// ----------------------------------------------------------------------------
// A calibration request (cmd 0) widens the stored X and Y extremes and loads
// a zero result into the output register once that register is free. A heading
// request (cmd 1) subtracts the hard-iron offset (highest + lowest) / 2 from
// each axis and runs a vectoring CORDIC with one shared shift-and-add unit, one
// step per cycle, through S_PREP, the CORDIC steps in S_ITER, S_ROUND and
// S_FIN, where the result is loaded into the output register once it is free;
// the next request can be taken in the cycle after that load. The block takes one
// request at a time; a finished result waiting in the output register does not
// hold off the next request, only the load of its own result.
module compass_heading_with_calibration (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic                                   cmd,
	input  logic signed [chc_pkg::SAMPLE_BITS-1:0] mag_x,
	input  logic signed [chc_pkg::SAMPLE_BITS-1:0] mag_y,
	output logic                                   heading_valid,
	input  logic                                   heading_ready,
	output logic        [chc_pkg::DEG_W-1:0]       heading_deg,
	output logic                                   is_heading
);

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_ITER, S_ROUND, S_FIN} state_t;

	localparam int PAD_W = chc_pkg::VEC_W - chc_pkg::CORR_W - chc_pkg::FRAC_BITS;

	state_t state_q;

	logic signed [chc_pkg::SAMPLE_BITS-1:0] x_lowest_q, x_highest_q;
	logic signed [chc_pkg::SAMPLE_BITS-1:0] y_lowest_q, y_highest_q;
	logic signed [chc_pkg::SAMPLE_BITS-1:0] sample_x_q, sample_y_q;
	logic signed [chc_pkg::VEC_W-1:0]       x_q, y_q;
	logic signed [chc_pkg::Z_W-1:0]         z_q;
	logic        [chc_pkg::STEP_W-1:0]      step_q;
	logic                                   zero_vec_q;
	logic        [chc_pkg::DEG_W-1:0]       result_q;
	logic                                   result_heading_q;
	logic                                   out_valid_q;
	logic        [chc_pkg::DEG_W-1:0]       out_deg_q;
	logic                                   out_heading_q;

	logic signed [chc_pkg::CORR_W-1:0] off_x, off_y, corr_x, corr_y;
	logic signed [chc_pkg::VEC_W-1:0]  start_x, start_y;
	logic signed [chc_pkg::VEC_W-1:0]  x_sh, y_sh, x_nx, y_nx;
	logic signed [chc_pkg::Z_W-1:0]    atan_val, z_nx, z_fix, z_rnd;
	logic        [chc_pkg::DEG_W-1:0]  deg_raw;
	logic                              y_neg;
	logic                              accept;
	logic                              out_free;

	assign accept        = sample_valid && sample_ready;
	assign sample_ready  = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || heading_ready;
	assign heading_valid = out_valid_q;
	assign heading_deg   = out_deg_q;
	assign is_heading    = out_heading_q;

	always_comb begin
		off_x  = (chc_pkg::CORR_W'(x_highest_q) + chc_pkg::CORR_W'(x_lowest_q)) >>> 1;
		off_y  = (chc_pkg::CORR_W'(y_highest_q) + chc_pkg::CORR_W'(y_lowest_q)) >>> 1;
		corr_x = chc_pkg::CORR_W'(sample_x_q) - off_x;
		corr_y = chc_pkg::CORR_W'(sample_y_q) - off_y;
		start_x = {{PAD_W{corr_x[chc_pkg::CORR_W-1]}}, corr_x, chc_pkg::FRAC_BITS'(0)};
		start_y = {{PAD_W{corr_y[chc_pkg::CORR_W-1]}}, corr_y, chc_pkg::FRAC_BITS'(0)};
	end

	always_comb begin
		y_neg    = y_q[chc_pkg::VEC_W-1];
		x_sh     = x_q >>> step_q;
		y_sh     = y_q >>> step_q;
		atan_val = chc_pkg::atan_deg_q16(chc_pkg::ATAN_IDX_W'(step_q));
		if (y_neg) begin
			x_nx = x_q - y_sh;
			y_nx = y_q + x_sh;
			z_nx = z_q - atan_val;
		end else begin
			x_nx = x_q + y_sh;
			y_nx = y_q - x_sh;
			z_nx = z_q + atan_val;
		end
	end

	always_comb begin
		z_fix   = z_q[chc_pkg::Z_W-1] ? z_q + chc_pkg::FULL_TURN_Q : z_q;
		z_rnd   = (z_fix + chc_pkg::ROUND_HALF) >>> chc_pkg::FRAC_BITS;
		deg_raw = z_rnd[chc_pkg::DEG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_lowest_q  <= '0;
			x_highest_q <= '0;
			y_lowest_q  <= '0;
			y_highest_q <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (out_valid_q && heading_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_x_q <= mag_x;
						sample_y_q <= mag_y;
						if (cmd) begin
							state_q <= S_PREP;
						end else begin
							if (mag_x < x_lowest_q)  x_lowest_q  <= mag_x;
							if (mag_x > x_highest_q) x_highest_q <= mag_x;
							if (mag_y < y_lowest_q)  y_lowest_q  <= mag_y;
							if (mag_y > y_highest_q) y_highest_q <= mag_y;
							result_q         <= '0;
							result_heading_q <= 1'b0;
							state_q          <= S_FIN;
						end
					end
				end
				S_PREP: begin
					zero_vec_q <= (corr_x == '0) && (corr_y == '0);
					step_q     <= '0;
					if (corr_x[chc_pkg::CORR_W-1]) begin
						x_q <= -start_x;
						y_q <= -start_y;
						z_q <= chc_pkg::HALF_TURN_Q;
					end else begin
						x_q <= start_x;
						y_q <= start_y;
						z_q <= '0;
					end
					state_q <= S_ITER;
				end
				S_ITER: begin
					x_q <= x_nx;
					y_q <= y_nx;
					z_q <= z_nx;
					if (step_q == chc_pkg::STEP_W'(chc_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_ROUND;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_ROUND: begin
					if (zero_vec_q || deg_raw == chc_pkg::DEG_FULL) begin
						result_q <= '0;
					end else begin
						result_q <= deg_raw;
					end
					result_heading_q <= 1'b1;
					state_q          <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_deg_q     <= result_q;
						out_heading_q <= result_heading_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample_ready)
		else $error("Block stayed ready after taking a request.");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_valid && is_heading |-> heading_deg < chc_pkg::DEG_FULL)
		else $error("Heading out of range.");

	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		heading_valid && !is_heading |-> heading_deg == '0)
		else $error("Calibration result is not zero.");

	a_extremes_order: assert property (@(posedge clk) disable iff (!arst_n)
		(x_lowest_q <= x_highest_q) && (y_lowest_q <= y_highest_q))
		else $error("Stored extremes are out of order.");

endmodule
